// ----- rtl/dtt_pkg.sv -----
package dtt_pkg;

  localparam int TILE_PIXELS = 64;
  localparam int TILE_SHIFT  = 6;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LIST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN_X,
    ST_SPAN_Y,
    ST_MARK,
    ST_LIST,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clear;
    logic set;
  } map_cmd_t;

endpackage

// ----- rtl/dtt_span.sv -----
module dtt_span #(
  parameter int CNT_W = 4
) (
  input  logic signed [15:0] org_i,
  input  logic signed [15:0] len_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic [8:0]         first_o,
  output logic [CNT_W-1:0]   end_o
);
  import dtt_pkg::*;

  logic signed [17:0] org_s;
  logic signed [17:0] len_s;
  logic signed [17:0] org_c;
  logic signed [17:0] len_c;
  logic [16:0]        sum;
  logic [10:0]        end_raw;

  always_comb begin
    org_s = 18'(org_i);
    len_s = 18'(len_i);
    if (org_s < 0) begin
      len_c = len_s + org_s;
      org_c = '0;
    end else begin
      len_c = len_s;
      org_c = org_s;
    end
    if (len_c < 0) begin
      len_c = '0;
    end
    sum     = 17'(org_c[15:0]) + 17'(len_c[15:0]) + 17'(TILE_PIXELS - 1);
    end_raw = 11'(sum >> TILE_SHIFT);
    first_o = 9'(org_c[15:0] >> TILE_SHIFT);
    end_o   = (end_raw > 11'(count_i)) ? count_i : CNT_W'(end_raw);
  end

endmodule

// ----- rtl/dtt_map.sv -----
module dtt_map #(
  parameter int ROWS = 8,
  parameter int COLS = 8,
  parameter int RIW  = 3,
  parameter int CIW  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtt_pkg::map_cmd_t  cmd_i,
  input  logic [RIW-1:0]     set_row_i,
  input  logic [COLS-1:0]    set_mask_i,
  input  logic [RIW-1:0]     rd_row_i,
  input  logic [CIW-1:0]     rd_col_i,
  output logic               rd_bit_o
);
  import dtt_pkg::*;

  logic [COLS-1:0] dirty_q [ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        dirty_q[r] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int r = 0; r < ROWS; r++) begin
        dirty_q[r] <= '0;
      end
    end else if (cmd_i.set) begin
      dirty_q[set_row_i] <= dirty_q[set_row_i] | set_mask_i;
    end
  end

  assign rd_bit_o = dirty_q[rd_row_i][rd_col_i];

endmodule

// ----- rtl/dirty_tile_tracker.sv -----
// dirty tile tracker: a bit map of 64x64 pixel tiles over a canvas.
// config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 width, 1 height)
//   and cfg_data_i; a config transaction clears the map. accepted while idle
//   and start_i low, so a config write never shares an edge with a command.
// command channel: a transaction is taken when start_i is high and busy_o low.
//   mark (0): busy through span setup (x then y through one span unit), then
//     through the tile rows touched, since the map is updated a row word
//     per cycle; a rectangle that spans no tile row ends after the setup.
//   clear (1): done at the accepting edge, busy_o stays low.
//   list (2): walks one tile per cycle over rows*cols tiles, then a finish state.
//     each dirty tile gives one result; a result is driven one tile found
//     later, the final one from the finish state with last_o set. an empty map
//     gives a single result with tile_present_o low and last_o high.
//   unknown operation (3): ignored.
// results: result_valid_o is a one-cycle strobe; the receiver cannot stall.
// reset: canvas sizes zero, map cleared, sequencer idle.
module dirty_tile_tracker #(
  parameter int TILE_COLUMNS_MAX = 8,
  parameter int TILE_ROWS_MAX    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] rect_w_i,
  input  logic signed [15:0] rect_h_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [8:0]         tile_left_o,
  output logic [8:0]         tile_top_o,
  output logic [6:0]         tile_width_o,
  output logic [6:0]         tile_height_o,
  output logic               tile_present_o,
  output logic               last_o
);
  import dtt_pkg::*;

  localparam int CNT_MAX = (TILE_COLUMNS_MAX > TILE_ROWS_MAX) ? TILE_COLUMNS_MAX
                                                              : TILE_ROWS_MAX;
  localparam int CNTW    = $clog2(CNT_MAX + 1);
  localparam int RIW     = (TILE_ROWS_MAX > 1) ? $clog2(TILE_ROWS_MAX) : 1;
  localparam int CIW     = (TILE_COLUMNS_MAX > 1) ? $clog2(TILE_COLUMNS_MAX) : 1;
  localparam int TCW     = 11 - TILE_SHIFT;

  state_e state_q, state_d;

  logic [9:0]  canvas_w_q, canvas_h_q;
  logic signed [15:0] rx_q, ry_q, rw_q, rh_q;
  logic [8:0]  x_first_q, x_first_d;
  logic [CNTW-1:0] x_end_q, x_end_d;
  logic [CNTW-1:0] y_end_q, y_end_d;
  logic [RIW-1:0] row_q, row_d;
  logic [CIW-1:0] col_q, col_d;
  logic        pend_valid_q, pend_valid_d;
  logic [RIW-1:0] pend_row_q, pend_row_d;
  logic [CIW-1:0] pend_col_q, pend_col_d;

  logic        accept;
  logic        cfg_write;
  logic [CNTW-1:0] cols, rows;
  logic [10:0] w_sum, h_sum;
  logic [TCW-1:0] w_tiles, h_tiles;

  logic signed [15:0] sp_org, sp_len;
  logic [CNTW-1:0] sp_count;
  logic [8:0]  sp_first;
  logic [CNTW-1:0] sp_end;

  map_cmd_t    map_cmd;
  logic [TILE_COLUMNS_MAX-1:0] col_mask;
  logic        rd_bit;
  logic        last_tile;

  logic        emit, emit_last;

  logic        res_valid_q, res_last_q, res_present_q;
  logic [8:0]  res_left_q, res_top_q;
  logic [6:0]  res_width_q, res_height_q;
  logic [10:0] right_full, bottom_full, right_clip, bottom_clip;
  logic [8:0]  pend_left, pend_top;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_i;
  assign accept      = start_i && !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // tile counts
  always_comb begin
    w_sum   = 11'(canvas_w_q) + 11'(TILE_PIXELS - 1);
    h_sum   = 11'(canvas_h_q) + 11'(TILE_PIXELS - 1);
    w_tiles = TCW'(w_sum >> TILE_SHIFT);
    h_tiles = TCW'(h_sum >> TILE_SHIFT);
    cols    = (w_tiles > TCW'(TILE_COLUMNS_MAX)) ? CNTW'(TILE_COLUMNS_MAX) : CNTW'(w_tiles);
    rows    = (h_tiles > TCW'(TILE_ROWS_MAX)) ? CNTW'(TILE_ROWS_MAX) : CNTW'(h_tiles);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= '0;
      canvas_h_q <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
      endcase
    end
  end

  // shared span unit, x axis first then y axis
  assign sp_org   = (state_q == ST_SPAN_X) ? rx_q : ry_q;
  assign sp_len   = (state_q == ST_SPAN_X) ? rw_q : rh_q;
  assign sp_count = (state_q == ST_SPAN_X) ? cols : rows;

  dtt_span #(
    .CNT_W (CNTW)
  ) u_span (
    .org_i   (sp_org),
    .len_i   (sp_len),
    .count_i (sp_count),
    .first_o (sp_first),
    .end_o   (sp_end)
  );

  always_comb begin
    for (int c = 0; c < TILE_COLUMNS_MAX; c++) begin
      col_mask[c] = (9'(c) >= x_first_q) && (CNTW'(c) < x_end_q);
    end
  end

  dtt_map #(
    .ROWS (TILE_ROWS_MAX),
    .COLS (TILE_COLUMNS_MAX),
    .RIW  (RIW),
    .CIW  (CIW)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (map_cmd),
    .set_row_i  (row_q),
    .set_mask_i (col_mask),
    .rd_row_i   (row_q),
    .rd_col_i   (col_q),
    .rd_bit_o   (rd_bit)
  );

  assign last_tile = (CNTW'(col_q) + 1'b1 == cols) && (CNTW'(row_q) + 1'b1 == rows);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_q <= rect_x_i;
      ry_q <= rect_y_i;
      rw_q <= rect_w_i;
      rh_q <= rect_h_i;
    end
    x_first_q  <= x_first_d;
    x_end_q    <= x_end_d;
    y_end_q    <= y_end_d;
    row_q      <= row_d;
    col_q      <= col_d;
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    x_first_d     = x_first_q;
    x_end_d       = x_end_q;
    y_end_d       = y_end_q;
    row_d         = row_q;
    col_d         = col_q;
    pend_valid_d  = pend_valid_q;
    pend_row_d    = pend_row_q;
    pend_col_d    = pend_col_q;
    map_cmd.clear = cfg_write;
    map_cmd.set   = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(operation_i))
            OP_MARK:  state_d = ST_SPAN_X;
            OP_CLEAR: map_cmd.clear = 1'b1;
            OP_LIST: begin
              pend_valid_d = 1'b0;
              row_d        = '0;
              col_d        = '0;
              state_d      = ((rows == '0) || (cols == '0)) ? ST_FINISH : ST_LIST;
            end
            OP_NONE: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SPAN_X: begin
        x_first_d = sp_first;
        x_end_d   = sp_end;
        state_d   = ST_SPAN_Y;
      end
      ST_SPAN_Y: begin
        y_end_d = sp_end;
        row_d   = RIW'(sp_first);
        state_d = (sp_first < 9'(sp_end)) ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        map_cmd.set = 1'b1;
        row_d       = row_q + 1'b1;
        if (CNTW'(row_q) + 1'b1 == y_end_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (rd_bit) begin
          emit         = pend_valid_q;
          pend_valid_d = 1'b1;
          pend_row_d   = row_q;
          pend_col_d   = col_q;
        end
        if (last_tile) begin
          state_d = ST_FINISH;
        end else if (CNTW'(col_q) + 1'b1 == cols) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_FINISH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result formatting, clipped at the canvas edge
  always_comb begin
    pend_left   = 9'(pend_col_q) << TILE_SHIFT;
    pend_top    = 9'(pend_row_q) << TILE_SHIFT;
    right_full  = 11'(pend_left) + 11'(TILE_PIXELS);
    bottom_full = 11'(pend_top) + 11'(TILE_PIXELS);
    right_clip  = (right_full > 11'(canvas_w_q)) ? 11'(canvas_w_q) : right_full;
    bottom_clip = (bottom_full > 11'(canvas_h_q)) ? 11'(canvas_h_q) : bottom_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_last_q    <= emit_last;
      res_present_q <= pend_valid_q;
      if (pend_valid_q) begin
        res_left_q   <= pend_left;
        res_top_q    <= pend_top;
        res_width_q  <= 7'(right_clip - 11'(pend_left));
        res_height_q <= 7'(bottom_clip - 11'(pend_top));
      end else begin
        res_left_q   <= '0;
        res_top_q    <= '0;
        res_width_q  <= '0;
        res_height_q <= '0;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign tile_left_o    = res_left_q;
  assign tile_top_o     = res_top_q;
  assign tile_width_o   = res_width_q;
  assign tile_height_o  = res_height_q;
  assign tile_present_o = res_present_q;
  assign last_o         = res_last_q;

endmodule

// ----- rtl/dtt_checker.sv -----
module dtt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         operation_i,
  input logic               cfg_ready_o,
  input logic               result_valid_o,
  input logic [8:0]         tile_left_o,
  input logic [8:0]         tile_top_o,
  input logic [6:0]         tile_width_o,
  input logic [6:0]         tile_height_o,
  input logic               tile_present_o,
  input logic               last_o
);
  import dtt_pkg::*;

  // an empty listing is a single final result with zero geometry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !tile_present_o |-> last_o && tile_left_o == '0 &&
      tile_top_o == '0 && tile_width_o == '0 && tile_height_o == '0)
    else $error("empty listing result malformed");

  // a dirty tile always covers some canvas area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && tile_present_o |-> tile_width_o != '0 && tile_height_o != '0)
    else $error("dirty tile with zero size");

  // nothing follows the final result of a listing directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result right after last");

  // clear finishes at the accepting edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == OP_CLEAR |=> !busy_o)
    else $error("clear left block busy");

  // config is only taken when no command is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o)
    else $error("config ready while busy");

endmodule

bind dirty_tile_tracker dtt_checker u_dtt_checker (.*);
